### hw/rtl/knn_brute_force_topk_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the k-nearest-neighbor search block
// Shared property forms, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef KNN_BRUTE_FORCE_TOPK_TOP_DEFINES_SVH
`define KNN_BRUTE_FORCE_TOPK_TOP_DEFINES_SVH

// Same-cycle implication.
`define KNN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KNN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/knn_pkg.sv
// ---------------------------------------------------------------------------
// knn_pkg
// Types and constants shared by the nearest-neighbor search modules.
// ---------------------------------------------------------------------------
package knn_pkg;
    localparam int MAX_POINTS = 4096;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int MAX_NB     = 64;
    localparam int NB_W       = $clog2(MAX_NB) + 1;
    localparam int RANK_W     = $clog2(MAX_NB);
    localparam int COORD_W    = 16;
    localparam int DIST_W     = 34;
    localparam int IDX_W      = 12;
    localparam int FLUSH_CYC  = MAX_NB + 8;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] MODE_SUM       = 2'd0;
    localparam logic [1:0] MODE_EUCL      = 2'd1;
    localparam logic [1:0] MODE_MANH      = 2'd2;
    localparam logic [1:0] MODE_EUCL_ALT  = 2'd3;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_K    = 1'b1;

    // Candidate handed along the cell chain.
    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;
endpackage

### hw/rtl/knn_brute_force_topk_top.sv
// ---------------------------------------------------------------------------
// knn_brute_force_topk_top
// Brute-force k-nearest-neighbor search over up to 4096 stored 3-D points.
// ---------------------------------------------------------------------------
// A load transfer appends a point (ignored once 4096 are held) and a clear
// transfer empties the set. A query transfer scans every stored point through
// the point memory, one point per cycle, into a four-stage distance pipeline
// and then a chain of 64 insertion cells that keeps the nearest candidates
// sorted. A query occupies the block while its N stored points are scanned and
// the pipeline and the cell chain drain, and then for min(N, K) result
// transfers (K of zero taken as one, K above 64 as 64), one per cycle while
// the sink is ready. Input is not taken during a query. Ties go to the lower
// load index, and the last result of a query carries tlast.
module knn_brute_force_topk_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // op, coord_x, coord_y, coord_z, zero pad
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [55:0] m_axis_tdata,  // neighbor_index, neighbor_distance, rank, pad
    output logic        m_axis_tlast
);
    import knn_pkg::*;
    `include "knn_brute_force_topk_top_defines.svh"

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    logic [1:0]       r_mode;
    logic [6:0]       r_k;
    logic [CNT_W-1:0] r_count, r_scan;
    logic [NB_W-1:0]  r_n, n_k_eff;
    logic [6:0]       r_flush;
    logic [RANK_W-1:0] r_rank;
    t_point           r_query, r_rd;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    t_point           r_mem [MAX_POINTS];

    logic [1:0]  in_op;
    t_point      in_pt;
    logic        in_xfer, out_xfer, last_res;
    t_cand       dist_cand;
    t_cand       chain_pass [MAX_NB+1];
    t_cand       chain_held [MAX_NB+1];

    assign in_op    = s_axis_tdata[1:0];
    assign in_pt.x  = s_axis_tdata[17:2];
    assign in_pt.y  = s_axis_tdata[33:18];
    assign in_pt.z  = s_axis_tdata[49:34];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign last_res = (NB_W'(r_rank) + NB_W'(1)) == r_n;

    // Effective K: zero acts as one, anything above the chain length saturates.
    always_comb begin
        if (r_k == 7'd0) begin
            n_k_eff = NB_W'(1);
        end else if (r_k > 7'(MAX_NB)) begin
            n_k_eff = NB_W'(MAX_NB);
        end else begin
            n_k_eff = NB_W'(r_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EUCL;
            r_k    <= 7'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_data[1:0];
                CFG_K:    r_k    <= i_cfg_data;
                default:  r_k    <= r_k;
            endcase
        end
    end

    // Point memory: written on load, read once per scan cycle.
    always_ff @(posedge i_clk) begin
        if (in_xfer && in_op == OP_LOAD && r_count < CNT_W'(MAX_POINTS)) begin
            r_mem[r_count[PT_AW-1:0]] <= in_pt;
        end
        r_rd     <= r_mem[r_scan[PT_AW-1:0]];
        r_rd_idx <= IDX_W'(r_scan);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_scan   <= '0;
            r_rd_vld <= 1'b0;
            r_flush  <= '0;
            r_rank   <= '0;
            r_n      <= '0;
        end else begin
            r_rd_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (in_op)
                            OP_LOAD: begin
                                if (r_count < CNT_W'(MAX_POINTS)) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_CLEAR: r_count <= '0;
                            OP_QUERY: begin
                                if (r_count != '0) begin
                                    r_query <= in_pt;
                                    r_scan  <= '0;
                                    r_rank  <= '0;
                                    r_n     <= (r_count < CNT_W'(n_k_eff))
                                               ? NB_W'(r_count) : n_k_eff;
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_scan   <= r_scan + CNT_W'(1);
                    if (r_scan + CNT_W'(1) == r_count) begin
                        r_flush <= '0;
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_flush <= r_flush + 7'd1;
                    if (r_flush == 7'(FLUSH_CYC - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_xfer) begin
                        r_rank <= r_rank + RANK_W'(1);
                        if (last_res) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    knn_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_query (r_query),
        .i_ref   (r_rd),
        .i_vld   (r_rd_vld),
        .i_idx   (r_rd_idx),
        .o_cand  (dist_cand)
    );

    assign chain_pass[0]      = dist_cand;
    assign chain_held[MAX_NB] = '0;

    // Insertion chain; during result readout every cell takes its right
    // neighbor's entry so the head always holds the next result.
    for (genvar g = 0; g < MAX_NB; g++) begin : g_cell
        knn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (in_xfer),
            .i_shift (out_xfer),
            .i_cand  (chain_pass[g]),
            .i_next  (chain_held[g+1]),
            .o_pass  (chain_pass[g+1]),
            .o_held  (chain_held[g])
        );
    end

    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tlast  = last_res;
    assign m_axis_tdata  = {4'd0, r_rank, chain_held[0].distance, chain_held[0].idx};

    `KNN_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input taken during readout")
    `KNN_ASSERT_NOW(a_head_valid, m_axis_tvalid, chain_held[0].vld, "result from empty cell")
    `KNN_ASSERT_NEXT(a_last_idle, out_xfer && m_axis_tlast, s_axis_tready, "no return to idle")
endmodule

### hw/rtl/knn_dist.sv
// ---------------------------------------------------------------------------
// knn_dist
// Four-stage distance pipeline between a query and one stored point.
// ---------------------------------------------------------------------------
module knn_dist (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_mode,
    input  knn_pkg::t_point        i_query,
    input  knn_pkg::t_point        i_ref,
    input  logic                   i_vld,
    input  logic [knn_pkg::IDX_W-1:0] i_idx,
    output knn_pkg::t_cand         o_cand
);
    import knn_pkg::*;

    logic signed [COORD_W:0]   r_dx, r_dy, r_dz;
    logic signed [COORD_W+2:0] r_sd;
    logic [COORD_W:0]          r_ax, r_ay, r_az;
    logic [COORD_W+1:0]        r_as;
    logic [2*COORD_W+1:0]      r_px, r_py, r_pz;
    logic [COORD_W+1:0]        r_man, r_sum;
    logic [3:0]                r_vld;
    logic [IDX_W-1:0]          r_idx1, r_idx2, r_idx3;
    logic [DIST_W-1:0]         r_dist;
    logic [IDX_W-1:0]          r_oidx;
    logic [DIST_W-1:0]         n_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
        r_dx   <= (COORD_W+1)'(i_query.x) - (COORD_W+1)'(i_ref.x);
        r_dy   <= (COORD_W+1)'(i_query.y) - (COORD_W+1)'(i_ref.y);
        r_dz   <= (COORD_W+1)'(i_query.z) - (COORD_W+1)'(i_ref.z);
        r_sd   <= (COORD_W+3)'(i_query.x) + (COORD_W+3)'(i_query.y)
                + (COORD_W+3)'(i_query.z) - (COORD_W+3)'(i_ref.x)
                - (COORD_W+3)'(i_ref.y) - (COORD_W+3)'(i_ref.z);
        r_idx1 <= i_idx;
        r_ax   <= r_dx[COORD_W] ? (COORD_W+1)'(-r_dx) : (COORD_W+1)'(r_dx);
        r_ay   <= r_dy[COORD_W] ? (COORD_W+1)'(-r_dy) : (COORD_W+1)'(r_dy);
        r_az   <= r_dz[COORD_W] ? (COORD_W+1)'(-r_dz) : (COORD_W+1)'(r_dz);
        r_as   <= r_sd[COORD_W+2] ? (COORD_W+2)'(-r_sd) : (COORD_W+2)'(r_sd);
        r_idx2 <= r_idx1;
        r_px   <= (2*COORD_W+2)'(r_ax) * (2*COORD_W+2)'(r_ax);
        r_py   <= (2*COORD_W+2)'(r_ay) * (2*COORD_W+2)'(r_ay);
        r_pz   <= (2*COORD_W+2)'(r_az) * (2*COORD_W+2)'(r_az);
        r_man  <= (COORD_W+2)'(r_ax) + (COORD_W+2)'(r_ay) + (COORD_W+2)'(r_az);
        r_sum  <= r_as;
        r_idx3 <= r_idx2;
        r_dist <= n_dist;
        r_oidx <= r_idx3;
    end

    assign o_cand = {r_vld[3], r_dist, r_oidx};

    always_comb begin
        case (i_mode)
            MODE_SUM:  n_dist = DIST_W'(r_sum);
            MODE_MANH: n_dist = DIST_W'(r_man);
            default:   n_dist = DIST_W'(r_px) + DIST_W'(r_py) + DIST_W'(r_pz);
        endcase
    end
endmodule

### hw/rtl/knn_cell.sv
// ---------------------------------------------------------------------------
// knn_cell
// One slot of the sorted insertion chain; keeps the smaller candidate.
// ---------------------------------------------------------------------------
module knn_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_shift,
    input  knn_pkg::t_cand  i_cand,
    input  knn_pkg::t_cand  i_next,
    output knn_pkg::t_cand  o_pass,
    output knn_pkg::t_cand  o_held
);
    import knn_pkg::*;

    t_cand r_held, r_pass;

    // Candidates can reach a cell out of load order, so equal distances are
    // ordered by index to keep the lower index ahead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_held.vld <= 1'b0;
            r_pass.vld <= 1'b0;
        end else if (i_shift) begin
            r_held <= i_next;
        end else if (i_cand.vld) begin
            if (!r_held.vld || i_cand.distance < r_held.distance ||
                (i_cand.distance == r_held.distance && i_cand.idx < r_held.idx)) begin
                r_held <= i_cand;
                r_pass <= r_held;
            end else begin
                r_pass <= i_cand;
            end
        end else begin
            r_pass.vld <= 1'b0;
        end
    end

    assign o_pass = r_pass;
    assign o_held = r_held;
endmodule
